// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- hdl/pwws_pkg.sv -----
// ----------------------------------------------------------------------------
// pwws_pkg
// types and constants of the page write-watch stamp unit
// ----------------------------------------------------------------------------
`default_nettype none

package pwws_pkg;

   // field widths
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 32;
   localparam int STAMP_W    = 64;
   localparam int PC_W       = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PAGE_SHIFT = 10;
   // signed offset width, holds addr - base + len
   localparam int OFF_W      = 34;

   // request modes
   localparam logic [1:0] MODE_CAPTURE = 2'd0;
   localparam logic [1:0] MODE_QUERY   = 2'd1;
   localparam logic [1:0] MODE_CHANGE  = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT   = 2'd1;

   localparam logic [PC_W-1:0]    PAGE_COUNT_RESET = 11'd1024;
   localparam logic [STAMP_W-1:0] STAMP_MAX        = '1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp_value;
      logic               range_unwatched;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/pwws_ram.sv -----
// ----------------------------------------------------------------------------
// pwws_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pwws_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/page_write_watch_stamps.sv -----
// ----------------------------------------------------------------------------
// page_write_watch_stamps_unit
// 64-bit generation stamps per 1 KiB page of a watched ram window
// ----------------------------------------------------------------------------
// One request beat is taken at a time; req_ready is high only when the
// sequencer is idle, while a finished response may still sit in the output
// register. All range math runs through one shared 34-bit adder in steps
// for the offset, the range end and the last byte, and the stamp ram has a
// single registered read port, so each page visited takes a read step,
// then a check step that may write back. Capture visits one page, query
// and change walk the range (a refused range skips the page walk), and
// clear zeroes every page. After reset the stamp ram is swept to zero with
// req_ready low; register writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module page_write_watch_stamps_unit #(
   parameter int PAGES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pwws_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pwws_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pwws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwws_pkg::CSR_DATA_W-1:0]     csr_data
);

   import pwws_pkg::*;

   localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic [AW-1:0] LAST_PAGE = AW'(PAGES - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_OFFSET = 8'b0000_0100,
      ST_END    = 8'b0000_1000,
      ST_BOUND  = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_CHECK  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        base_ff, base_in;
   logic [PC_W-1:0]          pcount_ff, pcount_in;
   logic [1:0]               mode_ff, mode_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic signed [OFF_W-1:0]  off_ff, off_in;
   logic signed [OFF_W-1:0]  end_ff, end_in;
   logic [AW-1:0]            cur_ff, cur_in;
   logic [AW-1:0]            last_ff, last_in;
   logic [STAMP_W-1:0]       seq_ff, seq_in;
   logic [STAMP_W-1:0]       res_stamp_ff, res_stamp_in;
   logic                     res_unw_ff, res_unw_in;
   logic                     notify_ff, notify_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]        win_base;
   logic [PC_W-1:0]          win_pages;
   logic signed [OFF_W-1:0]  win_size;
   logic signed [OFF_W-1:0]  alu_a, alu_b, alu_sum;
   logic signed [OFF_W-1:0]  end_clip, first_rel;
   logic [AW-1:0]            first_page;
   logic                     cap_ok, qry_ok, chg_ok;
   logic [STAMP_W-1:0]       seq_sat;

   logic                     ram_we;
   logic [STAMP_W-1:0]       ram_wdata;
   logic [STAMP_W-1:0]       ram_rdata;

   // window geometry
   assign win_base  = {base_ff[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   assign win_pages = (32'(pcount_ff) > 32'(PAGES)) ? PC_W'(PAGES) : pcount_ff;
   assign win_size  = $signed({{(OFF_W-PC_W-PAGE_SHIFT){1'b0}}, win_pages,
                               {PAGE_SHIFT{1'b0}}});

   // shared adder: offset, range end, last byte
   always_comb begin
      unique case (state_ff)
         ST_OFFSET: begin
            alu_a = $signed({2'b00, addr_ff});
            alu_b = -$signed({2'b00, win_base});
         end
         ST_END: begin
            alu_a = off_ff;
            alu_b = $signed({2'b00, len_ff});
         end
         ST_BOUND: begin
            alu_a = end_clip;
            alu_b = '1;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   assign alu_sum = alu_a + alu_b;

   // range clipping and checks
   assign end_clip   = (end_ff > win_size) ? win_size : end_ff;
   assign first_rel  = off_ff[OFF_W-1] ? '0 : off_ff;
   assign first_page = AW'(first_rel[OFF_W-1:PAGE_SHIFT]);

   assign cap_ok = (seq_ff != STAMP_MAX) && !off_ff[OFF_W-1] && (off_ff < win_size)
                   && (off_ff[PAGE_SHIFT-1:0] == '0);
   assign qry_ok = (len_ff != '0) && !off_ff[OFF_W-1] && (end_ff <= win_size);
   assign chg_ok = (len_ff != '0) && (end_clip > first_rel);

   // saturating sequence step
   assign seq_sat = (seq_ff == STAMP_MAX) ? STAMP_MAX : seq_ff + STAMP_W'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      pcount_in    = pcount_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      seq_in       = seq_ff;
      res_stamp_in = res_stamp_ff;
      res_unw_in   = res_unw_ff;
      notify_in    = notify_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_wdata    = '0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_in   = csr_data[ADDR_W-1:0];
            CSR_PAGE_COUNT:   pcount_in = csr_data[PC_W-1:0];
            default: ;
         endcase
      end

      // response beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in      = req_data.mode;
               addr_in      = req_data.address;
               len_in       = req_data.length;
               res_stamp_in = '0;
               res_unw_in   = 1'b0;
               if (req_data.mode == MODE_CLEAR) begin
                  cur_in    = '0;
                  notify_in = 1'b1;
                  state_in  = ST_CLEAR;
               end else begin
                  state_in = ST_OFFSET;
               end
            end
         end
         // zero sweep, also run after reset without a response
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (cur_ff == LAST_PAGE) begin
               state_in = notify_ff ? ST_DONE : ST_IDLE;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end
         ST_OFFSET: begin
            off_in   = alu_sum;
            state_in = ST_END;
         end
         ST_END: begin
            end_in   = alu_sum;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            last_in = AW'(alu_sum[OFF_W-1:PAGE_SHIFT]);
            cur_in  = first_page;
            case (mode_ff)
               MODE_CAPTURE: state_in = cap_ok ? ST_READ : ST_DONE;
               MODE_QUERY:   state_in = qry_ok ? ST_READ : ST_DONE;
               default:      state_in = chg_ok ? ST_READ : ST_DONE;
            endcase
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            case (mode_ff)
               MODE_CAPTURE: begin
                  if (ram_rdata == '0) begin
                     ram_we       = 1'b1;
                     ram_wdata    = seq_sat;
                     seq_in       = seq_sat;
                     res_stamp_in = seq_sat;
                  end else begin
                     res_stamp_in = ram_rdata;
                  end
                  state_in = ST_DONE;
               end
               MODE_QUERY: begin
                  if (ram_rdata != '0) begin
                     res_unw_in = 1'b0;
                     state_in   = ST_DONE;
                  end else if (cur_ff == last_ff) begin
                     res_unw_in = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     cur_in   = cur_ff + AW'(1);
                     state_in = ST_READ;
                  end
               end
               default: begin
                  // restamp a watched page
                  if (ram_rdata != '0) begin
                     ram_we    = 1'b1;
                     ram_wdata = seq_sat;
                     seq_in    = seq_sat;
                  end
                  if (cur_ff == last_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     cur_in   = cur_ff + AW'(1);
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.stamp_value     = res_stamp_ff;
               rsp_data_in.range_unwatched = res_unw_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         notify_ff    <= 1'b0;
         seq_ff       <= '0;
         base_ff      <= '0;
         pcount_ff    <= PAGE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         notify_ff    <= notify_in;
         seq_ff       <= seq_in;
         base_ff      <= base_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      off_ff       <= off_in;
      end_ff       <= end_in;
      last_ff      <= last_in;
      res_stamp_ff <= res_stamp_in;
      res_unw_ff   <= res_unw_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // stamp store
   pwws_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (PAGES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_ff),
      .wr_data (ram_wdata),
      .rd_addr (cur_ff),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/pwws_checker.sv -----
// ----------------------------------------------------------------------------
// pwws_checker
// port-level checks of the page write-watch stamp unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pwws_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input pwws_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pwws_pkg::rsp_type rsp_data
);

   // stalled response beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // stamp ram sweep after reset keeps requests out
   `ASSERT_IMPLY(a_reset_sweep, clock, reset, $past(reset), !req_ready)

   // one request beat at a time
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // an answer that flags an unwatched range never carries a stamp
   `ASSERT_IMPLY(a_query_no_stamp, clock, reset, rsp_valid && rsp_data.range_unwatched,
      rsp_data.stamp_value == '0)

   // accepted request beat carries a known mode
   `ASSERT_IMPLY(a_req_mode_known, clock, reset, req_valid && req_ready,
      !$isunknown(req_data.mode))

endmodule

bind page_write_watch_stamps_unit pwws_checker u_pwws_checker (.*);

`default_nettype wire
